>>> rtl/iso_date_to_epoch_day_core_assert.svh
// Assertion macros for the date parser checker.
`ifndef ISO_DATE_TO_EPOCH_DAY_CORE_ASSERT_SVH
`define ISO_DATE_TO_EPOCH_DAY_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define IDTE_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define IDTE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/idte_pkg.sv
// Types and constants for the ISO date to epoch day core.
`default_nettype none

package idte_pkg;

   // One input beat: a character or the end-of-string marker.
   typedef struct packed {
      logic [7:0] ch;
      logic       terminator;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic signed [22:0] day_number;
      logic               status;
   } rsp_type;

   // A parsed date handed from the parser to the arithmetic pipeline.
   typedef struct packed {
      logic [13:0] year;
      logic [6:0]  month;
      logic [6:0]  day;
      logic        ok;
   } job_type;

   // Character codes.
   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;
   localparam logic [7:0] CharDash = 8'h2D;

   // Character positions and counts within YYYY-MM-DD.
   localparam logic [3:0] DashPosYear  = 4'd4;
   localparam logic [3:0] DashPosMonth = 4'd7;
   localparam logic [3:0] LenFull      = 4'd10;
   localparam logic [3:0] CountMax     = 4'd11;

   // Status codes.
   localparam logic StatusOk  = 1'b0;
   localparam logic StatusBad = 1'b1;

   // Calendar constants.
   localparam logic [13:0] YearBias  = 14'd400;
   localparam logic [21:0] EraDays   = 22'd146097;
   localparam logic signed [23:0] DayOffset = 24'sd865565;

   // Day of the March-based year on which month index mp starts.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] days;
      unique case (mp)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

>>> rtl/iso_date_to_epoch_day_core.sv
// ISO date parser top level: a YYYY-MM-DD string in, a day count since 1970-01-01 out.
// The core takes one character beat per cycle, back to back, while req_stall is low,
// and gives one result beat per terminator. A result passes through the date queue,
// then five stages of constant-divide arithmetic and the output register. Input stalls
// only when QueueDepth parsed dates are waiting, which happens only after the result
// side has held rsp_stall. QueueDepth must be at least 2.
`default_nettype none

module iso_date_to_epoch_day_core #(
   parameter int QueueDepth = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire idte_pkg::req_type req_beat,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output idte_pkg::rsp_type      rsp_beat
);

   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;
   idte_pkg::job_type push_job;
   idte_pkg::job_type pop_job;

   idte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_beat   (req_beat),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   idte_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   idte_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_job     (pop_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat)
   );

endmodule

`default_nettype wire

>>> rtl/idte_front.sv
// Character parser: checks the YYYY-MM-DD form and collects the date fields.
`default_nettype none

module idte_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire idte_pkg::req_type req_beat,
   input  wire                    queue_full,
   output logic                   push,
   output idte_pkg::job_type      push_job
);

   logic [3:0]  char_count_ff, char_count_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic        bad_ff, bad_in;
   logic        accept;
   logic        is_digit;
   logic [3:0]  digit;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Finished date as it stands when the terminator arrives.
   always_comb begin
      push_job.year  = year_ff;
      push_job.month = month_ff;
      push_job.day   = day_ff;
      push_job.ok    = (char_count_ff == idte_pkg::LenFull) && !bad_ff &&
                       (month_ff >= 7'd1) && (month_ff <= 7'd12) &&
                       (day_ff >= 7'd1) && (day_ff <= 7'd31);
   end

   // Per-character checks and accumulator updates.
   always_comb begin
      is_digit      = (req_beat.ch >= idte_pkg::CharZero) &&
                      (req_beat.ch <= idte_pkg::CharNine);
      digit         = req_beat.ch[3:0];
      char_count_in = char_count_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      bad_in        = bad_ff;
      push          = 1'b0;
      if (accept) begin
         if (req_beat.terminator) begin
            push          = 1'b1;
            char_count_in = 4'd0;
            year_in       = 14'd0;
            month_in      = 7'd0;
            day_in        = 7'd0;
            bad_in        = 1'b0;
         end else begin
            priority if (char_count_ff == idte_pkg::DashPosYear ||
                         char_count_ff == idte_pkg::DashPosMonth) begin
               if (req_beat.ch != idte_pkg::CharDash) begin
                  bad_in = 1'b1;
               end
            end else if (char_count_ff < idte_pkg::LenFull) begin
               priority if (!is_digit) begin
                  bad_in = 1'b1;
               end else if (char_count_ff < idte_pkg::DashPosYear) begin
                  year_in = 14'(year_ff * 14'd10 + 14'(digit));
               end else if (char_count_ff < idte_pkg::DashPosMonth) begin
                  month_in = 7'(month_ff * 7'd10 + 7'(digit));
               end else begin
                  day_in = 7'(day_ff * 7'd10 + 7'(digit));
               end
            end else begin
               bad_in = bad_ff;
            end
            if (char_count_ff < idte_pkg::CountMax) begin
               char_count_in = char_count_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= 4'd0;
         year_ff       <= 14'd0;
         month_ff      <= 7'd0;
         day_ff        <= 7'd0;
         bad_ff        <= 1'b0;
      end else begin
         char_count_ff <= char_count_in;
         year_ff       <= year_in;
         month_ff      <= month_in;
         day_ff        <= day_in;
         bad_ff        <= bad_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/idte_queue.sv
// Short queue of parsed dates between the parser and the arithmetic pipeline.
`default_nettype none

module idte_queue #(
   parameter int Depth = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wire idte_pkg::job_type push_job,
   input  wire                    pop,
   output idte_pkg::job_type      pop_job,
   output logic                   full,
   output logic                   empty
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] DepthCnt = CountWidth'(Depth);

   idte_pkg::job_type entries_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full    = (count_ff == DepthCnt);
   assign empty   = (count_ff == '0);
   assign pop_job = entries_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

>>> rtl/idte_back.sv
// Arithmetic pipeline: converts a parsed date to a day count since 1970-01-01.
`default_nettype none

module idte_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    queue_empty,
   input  wire idte_pkg::job_type pop_job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output idte_pkg::rsp_type      rsp_beat
);

   logic advance;

   // Stage 1: biased year (always positive), month index from March, day.
   logic        v1_ff, ok1_ff;
   logic [13:0] yadj1_ff, yadj1_in;
   logic [3:0]  mp1_ff, mp1_in;
   logic [4:0]  day1_ff;

   // Stage 2: era and day of year.
   logic        v2_ff, ok2_ff;
   logic [13:0] yadj2_ff;
   logic [4:0]  era2_ff, era2_in;
   logic [8:0]  doy2_ff, doy2_in;
   logic [15:0] era_prod;

   // Stage 3: year of era.
   logic        v3_ff, ok3_ff;
   logic [4:0]  era3_ff;
   logic [8:0]  doy3_ff;
   logic [8:0]  yoe3_ff, yoe3_in;

   // Stage 4: year-of-era terms.
   logic        v4_ff, ok4_ff;
   logic [4:0]  era4_ff;
   logic [8:0]  doy4_ff;
   logic [17:0] yoe365_4_ff, yoe365_4_in;
   logic [6:0]  q4_4_ff, q4_4_in;
   logic [1:0]  c100_4_ff, c100_4_in;
   logic [12:0] c100_prod;

   // Stage 5: day of era and era days.
   logic        v5_ff, ok5_ff;
   logic [17:0] doe5_ff, doe5_in;
   logic [21:0] era_days5_ff, era_days5_in;

   // Output register.
   logic               rsp_valid_ff;
   logic signed [22:0] epoch_ff, epoch_in;
   logic               status_ff;
   logic signed [23:0] day_sum;

   // The whole pipeline moves when the output register can take a beat.
   assign advance = !(rsp_valid_ff && rsp_stall);
   assign pop     = advance && !queue_empty;

   // January and February count as months of the previous year.
   always_comb begin
      if (pop_job.month <= 7'd2) begin
         yadj1_in = 14'(pop_job.year + idte_pkg::YearBias - 14'd1);
         mp1_in   = 4'(pop_job.month + 7'd9);
      end else begin
         yadj1_in = 14'(pop_job.year + idte_pkg::YearBias);
         mp1_in   = 4'(pop_job.month - 7'd3);
      end
   end

   // Divide by 400 as (y / 16) * 41 / 1024, exact for the biased year range.
   always_comb begin
      era_prod = 16'(yadj1_ff[13:4]) * 16'd41;
      era2_in  = era_prod[14:10];
      doy2_in  = 9'(idte_pkg::month_start(mp1_ff) + 9'(day1_ff) - 9'd1);
   end

   always_comb begin
      yoe3_in = 9'(yadj2_ff - 14'(era2_ff) * 14'd400);
   end

   // Divide by 100 as (yoe / 4) * 41 / 1024.
   always_comb begin
      yoe365_4_in = 18'(yoe3_ff) * 18'd365;
      q4_4_in     = yoe3_ff[8:2];
      c100_prod   = 13'(q4_4_in) * 13'd41;
      c100_4_in   = c100_prod[11:10];
   end

   always_comb begin
      doe5_in      = 18'(yoe365_4_ff + 18'(q4_4_ff) - 18'(c100_4_ff) + 18'(doy4_ff));
      era_days5_in = 22'(22'(era4_ff) * idte_pkg::EraDays);
   end

   // The era bias of 400 years is folded into the day offset.
   always_comb begin
      day_sum  = $signed({2'b00, era_days5_ff}) + $signed({6'b000000, doe5_ff}) -
                 idte_pkg::DayOffset;
      epoch_in = ok5_ff ? day_sum[22:0] : 23'sd0;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= pop;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   // Stage data.
   always_ff @(posedge clock) begin
      if (advance) begin
         ok1_ff       <= pop_job.ok;
         yadj1_ff     <= yadj1_in;
         mp1_ff       <= mp1_in;
         day1_ff      <= pop_job.day[4:0];
         ok2_ff       <= ok1_ff;
         yadj2_ff     <= yadj1_ff;
         era2_ff      <= era2_in;
         doy2_ff      <= doy2_in;
         ok3_ff       <= ok2_ff;
         era3_ff      <= era2_ff;
         doy3_ff      <= doy2_ff;
         yoe3_ff      <= yoe3_in;
         ok4_ff       <= ok3_ff;
         era4_ff      <= era3_ff;
         doy4_ff      <= doy3_ff;
         yoe365_4_ff  <= yoe365_4_in;
         q4_4_ff      <= q4_4_in;
         c100_4_ff    <= c100_4_in;
         ok5_ff       <= ok4_ff;
         doe5_ff      <= doe5_in;
         era_days5_ff <= era_days5_in;
         epoch_ff     <= epoch_in;
         status_ff    <= ok5_ff ? idte_pkg::StatusOk : idte_pkg::StatusBad;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_beat.day_number = epoch_ff;
   assign rsp_beat.status     = status_ff;

endmodule

`default_nettype wire

>>> rtl/idte_checker.sv
// Port-level checks for the ISO date parser core, bound to its top level.
`default_nettype none

`include "iso_date_to_epoch_day_core_assert.svh"

module idte_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input wire idte_pkg::req_type req_beat,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input wire idte_pkg::rsp_type rsp_beat
);

   // A result beat waiting on the receiver keeps its value.
   `IDTE_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat), "result beat changed while stalled")

   // An invalid date always reports day zero.
   `IDTE_ASSERT_CLK(a_bad_is_zero, clock, reset, rsp_valid && rsp_beat.status |-> rsp_beat.day_number == 23'sd0, "invalid status with nonzero day")

   // A valid date stays within the range of years 0000 to 9999.
   `IDTE_ASSERT_CLK(a_day_range, clock, reset, rsp_valid && !rsp_beat.status |-> rsp_beat.day_number >= -23'sd719528 && rsp_beat.day_number <= 23'sd2932896, "day count out of range")

   // Reset empties the pipeline: no result beat in the cycle after it.
   `IDTE_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result beat right after reset")

   // A character beat can only be refused while a result is held back.
   `IDTE_ASSERT_CLK(a_stall_cause, clock, reset, req_valid && req_stall |-> rsp_valid && $past(rsp_valid && rsp_stall), "input stalled with no output back pressure")

endmodule

bind iso_date_to_epoch_day_core idte_checker u_checker (.*);

`default_nettype wire
